// ===== design/ups_q1_status_frame_parser_defines.svh =====
// Assertion macros shared by the parser RTL.
`ifndef UPS_Q1_STATUS_FRAME_PARSER_DEFINES_SVH
`define UPS_Q1_STATUS_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define UPS_Q1_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UPS_Q1_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ups_q1_pkg.sv =====
package ups_q1_pkg;

  localparam int unsigned WinLen = 47;
  localparam int unsigned NumFlags = 8;
  localparam int unsigned FlagBase = 38;
  localparam logic [7:0] CrByte = 8'd13;
  localparam logic [7:0] OpenParen = 8'h28;
  localparam logic [7:0] AsciiZero = 8'd48;
  localparam logic [7:0] AsciiOne = 8'd49;
  localparam logic [7:0] AsciiNine = 8'd57;
  localparam logic [7:0] PatDigit = 8'h44;  // 'D'
  localparam logic [7:0] PatFlag = 8'h46;   // 'F'
  localparam logic [7:0] PatCr = 8'h43;     // 'C'

  // Frame template, first character in the top byte. D is a digit, F is a
  // flag character, C is the closing carriage return; others match literally.
  localparam logic [WinLen*8-1:0] FramePattern =
    "(DDD.D DDD.D DDD.D DDD DD.D D.DD DD.D FFFFFFFFC";

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [13:0] input_volts_tenths;
    logic [13:0] fault_volts_tenths;
    logic [13:0] output_volts_tenths;
    logic [9:0]  load_percent;
    logic [9:0]  freq_tenths;
    logic [9:0]  cell_volts_hundredths;
    logic [9:0]  temp_tenths;
    logic [7:0]  status_flags;
  } out_t;

  function automatic byte_t pattern_at(input int unsigned pos);
    return FramePattern[(WinLen - 1 - pos) * 8 +: 8];
  endfunction

endpackage

// ===== design/ups_q1_status_frame_parser.sv =====
// Channel | Signals                          | Direction
// --------+----------------------------------+----------
// in      | in_valid_i, in_ready_o, in_item_i   | to block
// out     | out_valid_o, out_ready_i, out_item_o | from block
//
// One item is accepted per cycle while in_ready_o is high. The byte is first
// shifted into the 47-byte window register; the template compare and the decoded
// readings of that window are then registered as the result, if any.
// Reset clears the window, the frame-taken flag and both valid flags.
// A stalled output holds the compare stage, which then holds the input.
`include "ups_q1_status_frame_parser_defines.svh"

module ups_q1_status_frame_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ups_q1_pkg::in_t   in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ups_q1_pkg::out_t  out_item_o
);

  localparam int unsigned WinLen = ups_q1_pkg::WinLen;
  localparam int unsigned NumFlagsW = ups_q1_pkg::NumFlags;

  ups_q1_pkg::byte_t window_q [WinLen];
  ups_q1_pkg::byte_t window_d [WinLen];
  logic             stage_valid_q, stage_last_q;
  logic             frame_taken_q, frame_taken_d;
  logic             out_valid_q;
  ups_q1_pkg::out_t out_q, result;
  logic             in_fire, out_free, stage_fire, match, has_result;
  logic [NumFlagsW-1:0] flags;

  assign out_free   = !out_valid_q || out_ready_i;
  assign stage_fire = stage_valid_q && out_free;
  assign in_ready_o = !stage_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // Window update. A finished buffer empties the window before the next byte.
  always_comb begin
    for (int i = 0; i < WinLen; i++) begin
      window_d[i] = (stage_fire && stage_last_q) ? '0 : window_q[i];
    end
    if (in_fire) begin
      for (int i = 0; i < WinLen - 1; i++) begin
        window_d[i] = window_d[i + 1];
      end
      window_d[WinLen - 1] = in_item_i.data_byte;
    end
  end

  // Template compare over all window positions in parallel.
  always_comb begin
    ups_q1_pkg::byte_t p, b;
    match = 1'b1;
    for (int i = 0; i < WinLen; i++) begin
      p = ups_q1_pkg::pattern_at(i);
      b = window_q[i];
      priority if (p == ups_q1_pkg::PatDigit) begin
        if (b < ups_q1_pkg::AsciiZero || b > ups_q1_pkg::AsciiNine) match = 1'b0;
      end else if (p == ups_q1_pkg::PatFlag) begin
        if (b != ups_q1_pkg::AsciiZero && b != ups_q1_pkg::AsciiOne) match = 1'b0;
      end else if (p == ups_q1_pkg::PatCr) begin
        if (b != ups_q1_pkg::CrByte) match = 1'b0;
      end else begin
        if (b != p) match = 1'b0;
      end
    end
  end

  function automatic logic [3:0] dig(input ups_q1_pkg::byte_t b);
    return b[3:0];
  endfunction

  // Three digits and one fraction digit, as in "ddd.d".
  function automatic logic [13:0] val4(input logic [3:0] a, input logic [3:0] b,
                                       input logic [3:0] c, input logic [3:0] d);
    return 14'(a) * 14'd1000 + 14'(b) * 14'd100 + 14'(c) * 14'd10 + 14'(d);
  endfunction

  function automatic logic [9:0] val3(input logic [3:0] a, input logic [3:0] b,
                                      input logic [3:0] c);
    return 10'(a) * 10'd100 + 10'(b) * 10'd10 + 10'(c);
  endfunction

  always_comb begin
    for (int k = 0; k < NumFlagsW; k++) begin
      flags[k] = (window_q[ups_q1_pkg::FlagBase + k] == ups_q1_pkg::AsciiOne);
    end
  end

  assign has_result = !frame_taken_q && (match || stage_last_q);

  always_comb begin
    result = '0;
    result.status = !match;
    if (match) begin
      result.input_volts_tenths = val4(dig(window_q[1]), dig(window_q[2]),
                                       dig(window_q[3]), dig(window_q[5]));
      result.fault_volts_tenths = val4(dig(window_q[7]), dig(window_q[8]),
                                       dig(window_q[9]), dig(window_q[11]));
      result.output_volts_tenths = val4(dig(window_q[13]), dig(window_q[14]),
                                        dig(window_q[15]), dig(window_q[17]));
      result.load_percent = val3(dig(window_q[19]), dig(window_q[20]),
                                 dig(window_q[21]));
      result.freq_tenths = val3(dig(window_q[23]), dig(window_q[24]),
                                dig(window_q[26]));
      result.cell_volts_hundredths = val3(dig(window_q[28]), dig(window_q[30]),
                                          dig(window_q[31]));
      result.temp_tenths = val3(dig(window_q[33]), dig(window_q[34]),
                                dig(window_q[36]));
      result.status_flags = flags;
    end
  end

  always_comb begin
    frame_taken_d = frame_taken_q;
    if (stage_fire) begin
      if (stage_last_q) begin
        frame_taken_d = 1'b0;
      end else if (match) begin
        frame_taken_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WinLen; i++) begin
        window_q[i] <= '0;
      end
      stage_valid_q <= 1'b0;
      stage_last_q  <= 1'b0;
      frame_taken_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      window_q      <= window_d;
      frame_taken_q <= frame_taken_d;
      if (in_fire) begin
        stage_valid_q <= 1'b1;
        stage_last_q  <= in_item_i.last_byte;
      end else if (stage_fire) begin
        stage_valid_q <= 1'b0;
      end
      if (stage_fire && has_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_fire && has_result) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `UPS_Q1_ASSERT_IMP(a_err_fields_zero, out_valid_o && out_item_o.status,
    out_item_o.status_flags == '0 && out_item_o.input_volts_tenths == '0,
    "error item carries nonzero fields")
  `UPS_Q1_ASSERT_IMP(a_stall_needs_stage, !in_ready_o, stage_valid_q && out_valid_q,
    "input stalled without a blocked stage")
  `UPS_Q1_ASSERT_NXT(a_last_clears_taken, stage_fire && stage_last_q, !frame_taken_q,
    "frame flag survived end of buffer")
  `UPS_Q1_ASSERT_NXT(a_one_frame, frame_taken_q && stage_fire && !stage_last_q,
    frame_taken_q, "frame flag dropped inside a buffer")

endmodule

// ===== tb/sv/ups_q1_status_frame_parser_tb.sv =====
module ups_q1_status_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WinLen = ups_q1_pkg::WinLen;

  typedef enum int {FillLow, FillHigh, FillRandom} fill_e;

  localparam ups_q1_pkg::byte_t Dot = 8'h2E;
  localparam ups_q1_pkg::byte_t Space = 8'h20;

  // Q1 reply layout, first character in the top byte. D marks a digit, F a flag
  // character and C the closing carriage return.
  localparam logic [WinLen*8-1:0] Q1Layout =
    "(DDD.D DDD.D DDD.D DDD DD.D D.DD DD.D FFFFFFFFC";

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  ups_q1_pkg::in_t  in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  ups_q1_pkg::out_t out_item_o;

  ups_q1_pkg::byte_t recent_bytes[WinLen];
  bit                frame_seen;
  ups_q1_pkg::out_t  pending_results[$];
  int unsigned       error_count = 0;
  int unsigned       bytes_sent = 0;
  bit                idle_on = 1'b0;

  ups_q1_status_frame_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic ups_q1_pkg::byte_t layout_char(input int unsigned pos);
    return Q1Layout[(WinLen - 1 - pos) * 8 +: 8];
  endfunction

  function automatic void clear_window();
    foreach (recent_bytes[i]) recent_bytes[i] = 8'h00;
    frame_seen = 1'b0;
  endfunction

  function automatic bit window_is_frame();
    ups_q1_pkg::byte_t t;
    ups_q1_pkg::byte_t b;
    for (int i = 0; i < WinLen; i++) begin
      t = layout_char(i);
      b = recent_bytes[i];
      if (t == ups_q1_pkg::PatDigit) begin
        if (b < ups_q1_pkg::AsciiZero || b > ups_q1_pkg::AsciiNine) return 1'b0;
      end else if (t == ups_q1_pkg::PatFlag) begin
        if (b != ups_q1_pkg::AsciiZero && b != ups_q1_pkg::AsciiOne) return 1'b0;
      end else if (t == ups_q1_pkg::PatCr) begin
        if (b != ups_q1_pkg::CrByte) return 1'b0;
      end else if (b != t) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic int unsigned decimal_at(input int unsigned pos, input int unsigned n);
    int unsigned v;
    v = 0;
    for (int k = 0; k < n; k++) begin
      v = v * 10 + (recent_bytes[pos + k] - ups_q1_pkg::AsciiZero);
    end
    return v;
  endfunction

  // Shifts one byte into the window and queues the reading it produces, if any.
  function automatic void predict_reading(input ups_q1_pkg::byte_t b, input bit last);
    ups_q1_pkg::out_t r;
    r = '0;
    for (int i = 0; i < WinLen - 1; i++) recent_bytes[i] = recent_bytes[i + 1];
    recent_bytes[WinLen - 1] = b;
    if (!frame_seen && window_is_frame()) begin
      r.input_volts_tenths = 14'(decimal_at(1, 3) * 10 + decimal_at(5, 1));
      r.fault_volts_tenths = 14'(decimal_at(7, 3) * 10 + decimal_at(11, 1));
      r.output_volts_tenths = 14'(decimal_at(13, 3) * 10 + decimal_at(17, 1));
      r.load_percent = 10'(decimal_at(19, 3));
      r.freq_tenths = 10'(decimal_at(23, 2) * 10 + decimal_at(26, 1));
      r.cell_volts_hundredths = 10'(decimal_at(28, 1) * 100 + decimal_at(30, 2));
      r.temp_tenths = 10'(decimal_at(33, 2) * 10 + decimal_at(36, 1));
      for (int k = 0; k < ups_q1_pkg::NumFlags; k++) begin
        r.status_flags[k] = (recent_bytes[ups_q1_pkg::FlagBase + k] == ups_q1_pkg::AsciiOne);
      end
      frame_seen = 1'b1;
      pending_results.push_back(r);
    end else if (last && !frame_seen) begin
      r.status = 1'b1;
      pending_results.push_back(r);
    end
    if (last) clear_window();
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("%0t ns mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [13:0] got,
                             input logic [13:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  always @(posedge clk_i) begin : check_results
    ups_q1_pkg::out_t got;
    ups_q1_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_item_o;
      if (pending_results.size() == 0) begin
        report_mismatch("reading arrived with none expected");
      end else begin
        want = pending_results.pop_front();
        check_field("status", 14'(got.status), 14'(want.status));
        check_field("input_volts_tenths", got.input_volts_tenths, want.input_volts_tenths);
        check_field("fault_volts_tenths", got.fault_volts_tenths, want.fault_volts_tenths);
        check_field("output_volts_tenths", got.output_volts_tenths,
                    want.output_volts_tenths);
        check_field("load_percent", 14'(got.load_percent), 14'(want.load_percent));
        check_field("freq_tenths", 14'(got.freq_tenths), 14'(want.freq_tenths));
        check_field("cell_volts_hundredths", 14'(got.cell_volts_hundredths),
                    14'(want.cell_volts_hundredths));
        check_field("temp_tenths", 14'(got.temp_tenths), 14'(want.temp_tenths));
        check_field("status_flags", 14'(got.status_flags), 14'(want.status_flags));
      end
    end
  end

  initial begin : drive_out_ready
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_byte(input ups_q1_pkg::byte_t b, input bit last);
    ups_q1_pkg::in_t item;
    item.data_byte = b;
    item.last_byte = last;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= item;
    do @(posedge clk_i); while (!in_ready_o);
    predict_reading(b, last);
    bytes_sent++;
  endtask

  task automatic send_reply(input ups_q1_pkg::byte_t reply[$]);
    foreach (reply[i]) send_byte(reply[i], i == reply.size() - 1);
  endtask

  function automatic void make_frame(ref ups_q1_pkg::byte_t reply[$], input fill_e fill);
    ups_q1_pkg::byte_t t;
    ups_q1_pkg::byte_t c;
    for (int i = 0; i < WinLen; i++) begin
      t = layout_char(i);
      if (t == ups_q1_pkg::PatDigit) begin
        case (fill)
          FillLow:  c = ups_q1_pkg::AsciiZero;
          FillHigh: c = ups_q1_pkg::AsciiNine;
          default:  c = 8'(ups_q1_pkg::AsciiZero + $urandom_range(0, 9));
        endcase
      end else if (t == ups_q1_pkg::PatFlag) begin
        case (fill)
          FillLow:  c = ups_q1_pkg::AsciiZero;
          FillHigh: c = ups_q1_pkg::AsciiOne;
          default:  c = 8'(ups_q1_pkg::AsciiZero + $urandom_range(0, 1));
        endcase
      end else if (t == ups_q1_pkg::PatCr) begin
        c = ups_q1_pkg::CrByte;
      end else begin
        c = t;
      end
      reply.push_back(c);
    end
  endfunction

  // Noise leans toward characters that occur in a frame, so partial frames turn up.
  function automatic void add_noise(ref ups_q1_pkg::byte_t reply[$], input int unsigned n);
    ups_q1_pkg::byte_t c;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       c = 8'(ups_q1_pkg::AsciiZero + $urandom_range(0, 9));
        1:       c = $urandom_range(0, 1) ? Dot : Space;
        2:       c = $urandom_range(0, 1) ? ups_q1_pkg::CrByte : ups_q1_pkg::OpenParen;
        default: c = 8'($urandom_range(0, 255));
      endcase
      reply.push_back(c);
    end
  endfunction

  function automatic void corrupt_byte(ref ups_q1_pkg::byte_t reply[$],
                                       input int unsigned pos);
    case ($urandom_range(0, 2))
      0:       reply[pos] = 8'($urandom_range(0, 255));
      1:       reply[pos] = reply[pos] + 8'd1;
      default: reply[pos] = reply[pos] - 8'd1;
    endcase
  endfunction

  task automatic test_directed_frames();
    ups_q1_pkg::byte_t reply[$];
    idle_on = 1'b0;
    // Lowest readings, matched on the final byte of the reply.
    reply = {};
    make_frame(reply, FillLow);
    send_reply(reply);
    // Highest readings with bytes around the frame; no error after the match.
    reply = {8'h00, 8'hFF};
    make_frame(reply, FillHigh);
    reply.push_back(8'hFF);
    reply.push_back(ups_q1_pkg::CrByte);
    send_reply(reply);
    // A second frame in the same reply is ignored.
    reply = {};
    make_frame(reply, FillRandom);
    make_frame(reply, FillRandom);
    send_reply(reply);
    // Replies too short to hold a frame end in an error.
    reply = {8'hFF};
    send_reply(reply);
    reply = {8'h00};
    send_reply(reply);
    reply = {};
    make_frame(reply, FillRandom);
    void'(reply.pop_front());
    send_reply(reply);
  endtask

  task automatic test_near_misses();
    int unsigned miss_pos[11] = '{29, 29, 30, 30, 1, 5, 38, 45, 46, 0, 6};
    ups_q1_pkg::byte_t miss_val[11] = '{8'h2C, ups_q1_pkg::AsciiZero, 8'h2F, 8'h3A,
                                        8'h2F, 8'h3A, 8'h32, 8'h2F, 8'h0A, 8'h5B,
                                        ups_q1_pkg::AsciiZero};
    ups_q1_pkg::byte_t reply[$];
    idle_on = 1'b1;
    foreach (miss_pos[i]) begin
      reply = {};
      make_frame(reply, FillRandom);
      reply[miss_pos[i]] = miss_val[i];
      // Broken frames at odd indices are followed by a good one in the same reply.
      if (i % 2) make_frame(reply, FillRandom);
      send_reply(reply);
    end
  endtask

  task automatic run_random_replies(input int unsigned byte_goal,
                                    input int unsigned reply_goal, input bit with_idle);
    ups_q1_pkg::byte_t reply[$];
    int unsigned       first_count;
    int unsigned       replies;
    int unsigned       frame_start;
    first_count = bytes_sent;
    replies = 0;
    while (bytes_sent - first_count < byte_goal || replies < reply_goal) begin
      reply = {};
      idle_on = with_idle && ($urandom_range(0, 3) != 0);
      add_noise(reply, $urandom_range(0, 6));
      frame_start = reply.size();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: make_frame(reply, FillRandom);
        6, 7: begin
          make_frame(reply, FillRandom);
          corrupt_byte(reply, frame_start + $urandom_range(0, WinLen - 1));
        end
        8: add_noise(reply, $urandom_range(1, 60));
        default: begin
          make_frame(reply, FillRandom);
          make_frame(reply, FillRandom);
        end
      endcase
      add_noise(reply, $urandom_range(0, 4));
      send_reply(reply);
      replies++;
    end
  endtask

  task automatic test_random_replies();
    run_random_replies(500, 8, 1'b1);
  endtask

  task automatic test_streaming_replies();
    run_random_replies(250, 4, 1'b0);
  endtask

  initial begin
    clear_window();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_frames();
    test_near_misses();
    test_random_replies();
    test_streaming_replies();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
